### hdl/pyramid_reduce_expand_blur_unit_macros.svh
// Assertion helpers used by the checker file
`ifndef PYRAMID_REDUCE_EXPAND_BLUR_UNIT_MACROS_SVH
`define PYRAMID_REDUCE_EXPAND_BLUR_UNIT_MACROS_SVH

// Checked at every rising edge outside reset
`define PRX_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included
`define PRX_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/prx_pkg.sv
// ----------------------------------------------------------------------------
// prx_pkg
// Shared constants and control types of the pyramid blur unit.
// ----------------------------------------------------------------------------
package prx_pkg;

	localparam int DEF_MAX_WIDTH     = 2048;
	localparam int DEF_MAX_HEIGHT    = 4096;
	localparam int DEF_PIXEL_BITS    = 16;
	localparam int DEF_FRACTION_BITS = 4;

	localparam int CFG_INDEX_BITS    = 2;
	localparam int CFG_DATA_BITS     = 16;
	localparam int FRAME_WIDTH_BITS  = 12;
	localparam int FRAME_HEIGHT_BITS = 13;
	localparam int RESET_FRAME_WIDTH  = 640;
	localparam int RESET_FRAME_HEIGHT = 480;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

	// results in flight plus results waiting at the output
	localparam int OFIFO_DEPTH = 8;

	// per-pixel control toward the reduce stage
	typedef struct packed {
		logic valid;
		logic y_even;
		logic y_first;
		logic y_last;
		logic x_even;
		logic x_first;
		logic x_last;
	} red_ctl_t;

	// per-result control toward the expand stage
	typedef struct packed {
		logic valid;
		logic last;
		logic x_odd;
	} exp_ctl_t;

endpackage

### hdl/prx_ctrl.sv
// ----------------------------------------------------------------------------
// prx_ctrl
// Frame counters, configuration registers, output readiness and credits.
// ----------------------------------------------------------------------------
module prx_ctrl #(
	parameter int MAX_WIDTH  = prx_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = prx_pkg::DEF_MAX_HEIGHT,
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int HALF_W = (MAX_WIDTH + 1) / 2,
	localparam int CW = $clog2(HALF_W + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [prx_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [prx_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                mode,
	input  logic                                pop,
	output prx_pkg::red_ctl_t                   red_ctl,
	output logic [XW-1:0]                       red_x,
	output logic [1:0]                          red_slot,
	output prx_pkg::exp_ctl_t                   exp_ctl,
	output logic [1:0]                          exp_slot_a,
	output logic [1:0]                          exp_slot_b,
	output logic [CW-1:0]                       exp_col
);

	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HWW = $clog2(MAX_HEIGHT + 1);
	localparam int YW  = $clog2(MAX_HEIGHT);
	localparam int OW  = $clog2(prx_pkg::OFIFO_DEPTH + 1);

	logic [prx_pkg::FRAME_WIDTH_BITS-1:0]  cfg_w_q;
	logic [prx_pkg::FRAME_HEIGHT_BITS-1:0] cfg_h_q;
	logic [XW-1:0]  ix_q, ix_n, ox_q;
	logic [HWW-1:0] iy_q, iy_n;
	logic [YW-1:0]  oy_q;
	logic [1:0]     islot_q, islot_n, oslot_q;
	logic [OW-1:0]  occ_q;

	logic [WW-1:0]  w_eff;
	logic [HWW-1:0] h_eff;
	logic [WW-1:0]  ix_inc;
	logic           in_acc, cfg_acc, take_pix, row_end, emit, last, cfg_hit;
	logic [WW:0]    ca_w, cb_w, cc_w, hw_w;
	logic [HWW:0]   a_w, b_w, rr_w, hh_w;
	logic           ready_out;

	function automatic logic [1:0] slot_inc(input logic [1:0] s);
		return (s == 2'd2) ? 2'd0 : s + 2'd1;
	endfunction

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_ready  = occ_q < OW'(prx_pkg::OFIFO_DEPTH);
	assign in_acc    = in_valid && in_ready;
	assign cfg_hit   = (cfg_index == prx_pkg::CFG_FRAME_WIDTH) ||
		(cfg_index == prx_pkg::CFG_FRAME_HEIGHT);

	always_comb begin
		if (cfg_w_q == '0)
			w_eff = WW'(1);
		else if (32'(cfg_w_q) > 32'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(cfg_w_q);
		if (cfg_h_q == '0)
			h_eff = HWW'(1);
		else if (32'(cfg_h_q) > 32'(MAX_HEIGHT))
			h_eff = HWW'(MAX_HEIGHT);
		else
			h_eff = HWW'(cfg_h_q);
	end

	// input position after this transaction
	always_comb begin
		take_pix = in_acc && !mode && (iy_q < h_eff);
		ix_inc   = WW'(ix_q) + WW'(1);
		row_end  = ix_inc == w_eff;
		ix_n     = ix_q;
		iy_n     = iy_q;
		islot_n  = islot_q;
		if (take_pix) begin
			if (row_end) begin
				ix_n = '0;
				iy_n = iy_q + HWW'(1);
				if (!iy_n[0])
					islot_n = slot_inc(islot_q);
			end else begin
				ix_n = XW'(ix_inc);
			end
		end
	end

	// last input sample that the next output depends on
	always_comb begin
		hw_w = ({1'b0, w_eff} + (WW+1)'(1)) >> 1;
		hh_w = ({1'b0, h_eff} + (HWW+1)'(1)) >> 1;
		ca_w = (WW+1)'(ox_q >> 1);
		a_w  = (HWW+1)'(oy_q >> 1);
		cb_w = ca_w;
		if (ox_q[0])
			cb_w = (ca_w + (WW+1)'(1) < hw_w) ? ca_w + (WW+1)'(1) : hw_w - (WW+1)'(1);
		b_w = a_w;
		if (oy_q[0])
			b_w = (a_w + (HWW+1)'(1) < hh_w) ? a_w + (HWW+1)'(1) : hh_w - (HWW+1)'(1);
		cc_w = ((cb_w << 1) + (WW+1)'(1) < {1'b0, w_eff}) ?
			(cb_w << 1) + (WW+1)'(1) : {1'b0, w_eff} - (WW+1)'(1);
		rr_w = ((b_w << 1) + (HWW+1)'(1) < {1'b0, h_eff}) ?
			(b_w << 1) + (HWW+1)'(1) : {1'b0, h_eff} - (HWW+1)'(1);
		ready_out = (rr_w < {1'b0, iy_n}) ||
			((rr_w == {1'b0, iy_n}) && (cc_w < (WW+1)'(ix_n)));
		emit = in_acc && ready_out;
		last = ((HWW)'(oy_q) == h_eff - HWW'(1)) && (WW'(ox_q) == w_eff - WW'(1));
	end

	always_comb begin
		red_ctl.valid   = take_pix;
		red_ctl.y_even  = !iy_q[0];
		red_ctl.y_first = iy_q == '0;
		red_ctl.y_last  = iy_q == h_eff - HWW'(1);
		red_ctl.x_even  = !ix_q[0];
		red_ctl.x_first = ix_q == '0;
		red_ctl.x_last  = WW'(ix_q) == w_eff - WW'(1);
		red_x           = ix_q;
		red_slot        = islot_q;
		exp_ctl.valid   = emit;
		exp_ctl.last    = last;
		exp_ctl.x_odd   = ox_q[0];
		exp_slot_a      = oslot_q;
		exp_slot_b      = (b_w == a_w) ? oslot_q : slot_inc(oslot_q);
		exp_col         = ox_q[0] ? CW'(cb_w) : CW'(ca_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= prx_pkg::FRAME_WIDTH_BITS'(prx_pkg::RESET_FRAME_WIDTH);
			cfg_h_q <= prx_pkg::FRAME_HEIGHT_BITS'(prx_pkg::RESET_FRAME_HEIGHT);
			ix_q    <= '0;
			iy_q    <= '0;
			islot_q <= '0;
			ox_q    <= '0;
			oy_q    <= '0;
			oslot_q <= '0;
			occ_q   <= '0;
		end else begin
			if (cfg_acc) begin
				unique case (cfg_index)
					prx_pkg::CFG_FRAME_WIDTH:
						cfg_w_q <= cfg_data[prx_pkg::FRAME_WIDTH_BITS-1:0];
					prx_pkg::CFG_FRAME_HEIGHT:
						cfg_h_q <= cfg_data[prx_pkg::FRAME_HEIGHT_BITS-1:0];
					default: ;
				endcase
				if (cfg_hit) begin
					ix_q    <= '0;
					iy_q    <= '0;
					islot_q <= '0;
					ox_q    <= '0;
					oy_q    <= '0;
					oslot_q <= '0;
				end
			end else if (emit && last) begin
				// frame done: restart all position counters
				ix_q    <= '0;
				iy_q    <= '0;
				islot_q <= '0;
				ox_q    <= '0;
				oy_q    <= '0;
				oslot_q <= '0;
			end else begin
				ix_q    <= ix_n;
				iy_q    <= iy_n;
				islot_q <= islot_n;
				if (emit) begin
					if (WW'(ox_q) + WW'(1) == w_eff) begin
						ox_q <= '0;
						oy_q <= oy_q + YW'(1);
						if (oy_q[0])
							oslot_q <= slot_inc(oslot_q);
					end else begin
						ox_q <= ox_q + XW'(1);
					end
				end
			end
			occ_q <= occ_q + OW'(emit) - OW'(pop);
		end
	end

endmodule

### hdl/prx_reduce.sv
// ----------------------------------------------------------------------------
// prx_reduce
// Input line store and the vertical and horizontal [1 2 1] reduce passes.
// ----------------------------------------------------------------------------
module prx_reduce #(
	parameter int MAX_WIDTH     = prx_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS    = prx_pkg::DEF_PIXEL_BITS,
	parameter int FRACTION_BITS = prx_pkg::DEF_FRACTION_BITS,
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int HALF_W = (MAX_WIDTH + 1) / 2,
	localparam int HA = $clog2(3 * HALF_W),
	localparam int DW = PIXEL_BITS + FRACTION_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  prx_pkg::red_ctl_t     ctl,
	input  logic [XW-1:0]         x,
	input  logic [1:0]            slot,
	input  logic [PIXEL_BITS-1:0] pixel,
	output logic                  hwr_en,
	output logic [HA-1:0]         hwr_addr,
	output logic [DW-1:0]         hwr_data
);

	localparam int LW = PIXEL_BITS + 2;
	localparam int SW = PIXEL_BITS + 4;
	localparam int TW = SW + FRACTION_BITS + 1;

	logic [LW-1:0] line_mem [MAX_WIDTH];
	logic [LW-1:0] line_rd_q, fwd_data_q;
	logic          fwd_q;

	prx_pkg::red_ctl_t     ctl_s1;
	logic [XW-1:0]         x_s1;
	logic [1:0]            slot_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [SW-1:0]         hacc_q, hprev_q;

	logic [LW-1:0] line, p, acc, vs, lwr_data;
	logic          lwr_en, done, store;
	logic [SW-1:0] vs_e, hacc_n, hsum;
	logic [TW-1:0] hround;
	logic [HA-1:0] off;

	always_comb begin
		line     = fwd_q ? fwd_data_q : line_rd_q;
		p        = LW'(pix_s1);
		acc      = (ctl_s1.y_first ? p : line) + (p << 1);
		vs       = '0;
		done     = 1'b0;
		lwr_en   = 1'b0;
		lwr_data = p;
		if (ctl_s1.y_even) begin
			if (ctl_s1.y_last) begin
				vs   = acc + p;
				done = 1'b1;
			end else begin
				lwr_en   = ctl_s1.valid;
				lwr_data = acc;
			end
		end else begin
			vs     = line + p;
			lwr_en = ctl_s1.valid;
			done   = 1'b1;
		end

		vs_e   = SW'(vs);
		hacc_n = (ctl_s1.x_first ? vs_e : hprev_q) + (vs_e << 1);
		if (ctl_s1.x_even) begin
			hsum  = hacc_n + vs_e;
			store = ctl_s1.x_last;
		end else begin
			hsum  = hacc_q + vs_e;
			store = 1'b1;
		end
		hround = {1'b0, hsum, FRACTION_BITS'(0)} + TW'(8);

		unique case (slot_s1)
			2'd1:    off = HA'(HALF_W);
			2'd2:    off = HA'(2 * HALF_W);
			default: off = '0;
		endcase
		hwr_en   = ctl_s1.valid && done && store;
		hwr_addr = off + HA'(x_s1 >> 1);
		hwr_data = hround[DW+3:4];
	end

	always_ff @(posedge clk) begin
		if (lwr_en)
			line_mem[x_s1] <= lwr_data;
		if (ctl.valid)
			line_rd_q <= line_mem[x];
		// the same column can come back on the next transaction
		fwd_q      <= lwr_en && (x_s1 == x);
		fwd_data_q <= lwr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s1 <= '0;
		else
			ctl_s1 <= ctl;
	end

	always_ff @(posedge clk) begin
		x_s1    <= x;
		slot_s1 <= slot;
		pix_s1  <= pixel;
		if (ctl_s1.valid && done) begin
			if (ctl_s1.x_even)
				hacc_q <= hacc_n;
			else
				hprev_q <= vs_e;
		end
	end

endmodule

### hdl/prx_expand.sv
// ----------------------------------------------------------------------------
// prx_expand
// Half-size row ring and the two-pass linear interpolation back to full size.
// ----------------------------------------------------------------------------
module prx_expand #(
	parameter int MAX_WIDTH     = prx_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS    = prx_pkg::DEF_PIXEL_BITS,
	parameter int FRACTION_BITS = prx_pkg::DEF_FRACTION_BITS,
	localparam int HALF_W = (MAX_WIDTH + 1) / 2,
	localparam int CW = $clog2(HALF_W + 1),
	localparam int HA = $clog2(3 * HALF_W),
	localparam int DW = PIXEL_BITS + FRACTION_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  prx_pkg::exp_ctl_t     ctl,
	input  logic [1:0]            slot_a,
	input  logic [1:0]            slot_b,
	input  logic [CW-1:0]         col,
	input  logic                  hwr_en,
	input  logic [HA-1:0]         hwr_addr,
	input  logic [DW-1:0]         hwr_data,
	output logic                  push,
	output logic [PIXEL_BITS-1:0] push_pixel,
	output logic                  push_last
);

	logic [DW-1:0] half_mem [3 * HALF_W];

	prx_pkg::exp_ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic [HA-1:0] addr_a, addr_b, addr_a_s1, addr_b_s1, addr_a_s2, addr_b_s2;
	logic [DW-1:0] rd_a_q, rd_b_q, prev_a_q, prev_b_q;
	logic [DW:0]   sum_top, sum_bot, sum_v;
	logic [DW-1:0] top, bot, v;
	logic [DW:0]   rnd;
	logic [PIXEL_BITS:0] o;

	function automatic logic [HA-1:0] row_base(input logic [1:0] s);
		logic [HA-1:0] r;
		unique case (s)
			2'd1:    r = HA'(HALF_W);
			2'd2:    r = HA'(2 * HALF_W);
			default: r = '0;
		endcase
		return r;
	endfunction

	assign addr_a = row_base(slot_a) + HA'(col);
	assign addr_b = row_base(slot_b) + HA'(col);

	// each result reads one new column; an odd column pairs it with the one before
	always_comb begin
		sum_top = {1'b0, prev_a_q} + {1'b0, rd_a_q} + (DW+1)'(1);
		sum_bot = {1'b0, prev_b_q} + {1'b0, rd_b_q} + (DW+1)'(1);
		top     = ctl_s3.x_odd ? sum_top[DW:1] : rd_a_q;
		bot     = ctl_s3.x_odd ? sum_bot[DW:1] : rd_b_q;
		sum_v   = {1'b0, top} + {1'b0, bot} + (DW+1)'(1);
		v       = sum_v[DW:1];
		rnd     = {1'b0, v} + (DW+1)'(1 << (FRACTION_BITS - 1));
		o       = rnd[DW:FRACTION_BITS];
		push       = ctl_s3.valid;
		push_pixel = o[PIXEL_BITS] ? {PIXEL_BITS{1'b1}} : o[PIXEL_BITS-1:0];
		push_last  = ctl_s3.last;
	end

	// read with the addresses delayed through the s1 and s2 registers, after the matching write landed
	always_ff @(posedge clk) begin
		if (hwr_en)
			half_mem[hwr_addr] <= hwr_data;
		if (ctl_s2.valid) begin
			rd_a_q <= half_mem[addr_a_s2];
			rd_b_q <= half_mem[addr_b_s2];
		end
		if (ctl_s3.valid) begin
			prev_a_q <= rd_a_q;
			prev_b_q <= rd_b_q;
		end
		addr_a_s1 <= addr_a;
		addr_b_s1 <= addr_b;
		addr_a_s2 <= addr_a_s1;
		addr_b_s2 <= addr_b_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

endmodule

### hdl/prx_ofifo.sv
// ----------------------------------------------------------------------------
// prx_ofifo
// Result queue between the fixed-latency pipeline and the output channel.
// ----------------------------------------------------------------------------
module prx_ofifo #(
	parameter int PIXEL_BITS = prx_pkg::DEF_PIXEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [PIXEL_BITS-1:0] push_pixel,
	input  logic                  push_last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIXEL_BITS-1:0] pixel_out,
	output logic                  frame_last,
	output logic                  pop
);

	localparam int DEPTH = prx_pkg::OFIFO_DEPTH;
	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [PIXEL_BITS:0] q_mem [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [NW-1:0] cnt_q;

	assign out_valid  = cnt_q != '0;
	assign pop        = out_valid && out_ready;
	assign pixel_out  = q_mem[rp_q][PIXEL_BITS-1:0];
	assign frame_last = q_mem[rp_q][PIXEL_BITS];

	always_ff @(posedge clk) begin
		if (push)
			q_mem[wp_q] <= {push_last, push_pixel};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			if (pop)
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			cnt_q <= cnt_q + NW'(push) - NW'(pop);
		end
	end

endmodule

### hdl/pyramid_reduce_expand_blur_unit.sv
// ----------------------------------------------------------------------------
// pyramid_reduce_expand_blur_unit
// Raster-stream Gaussian pyramid blur: one reduce step, then one expand step.
// ----------------------------------------------------------------------------
// Takes one transaction per clock and returns at most one result per
// transaction. Each pixel does one read and one write of the input line store
// (one port each), and each result one column read of the half-size row ring
// on its two read ports, so the sustained rate is one item per cycle. A result
// passes the expand registers ctl_s1, ctl_s2 and ctl_s3 before it reaches the
// output queue; the input stalls only while eight results are in flight or
// waiting to be taken. Both stores are read only after being written in the
// current frame, so there is no clearing pass after reset. Width and height
// writes restart the frame; all writes are accepted in any cycle.
module pyramid_reduce_expand_blur_unit #(
	parameter int MAX_WIDTH     = prx_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT    = prx_pkg::DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS    = prx_pkg::DEF_PIXEL_BITS,
	parameter int FRACTION_BITS = prx_pkg::DEF_FRACTION_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [prx_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [prx_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               mode,
	input  logic [PIXEL_BITS-1:0]              pixel_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [PIXEL_BITS-1:0]              pixel_out,
	output logic                               frame_last
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int HALF_W = (MAX_WIDTH + 1) / 2;
	localparam int CW = $clog2(HALF_W + 1);
	localparam int HA = $clog2(3 * HALF_W);
	localparam int DW = PIXEL_BITS + FRACTION_BITS;

	prx_pkg::red_ctl_t red_ctl;
	prx_pkg::exp_ctl_t exp_ctl;
	logic [XW-1:0] red_x;
	logic [1:0]    red_slot, exp_slot_a, exp_slot_b;
	logic [CW-1:0] exp_col;
	logic          hwr_en, push, push_last, pop;
	logic [HA-1:0] hwr_addr;
	logic [DW-1:0] hwr_data;
	logic [PIXEL_BITS-1:0] push_pixel;

	prx_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.pop       (pop),
		.red_ctl   (red_ctl),
		.red_x     (red_x),
		.red_slot  (red_slot),
		.exp_ctl   (exp_ctl),
		.exp_slot_a(exp_slot_a),
		.exp_slot_b(exp_slot_b),
		.exp_col   (exp_col)
	);

	prx_reduce #(
		.MAX_WIDTH    (MAX_WIDTH),
		.PIXEL_BITS   (PIXEL_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (red_ctl),
		.x       (red_x),
		.slot    (red_slot),
		.pixel   (pixel_in),
		.hwr_en  (hwr_en),
		.hwr_addr(hwr_addr),
		.hwr_data(hwr_data)
	);

	prx_expand #(
		.MAX_WIDTH    (MAX_WIDTH),
		.PIXEL_BITS   (PIXEL_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_expand (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (exp_ctl),
		.slot_a    (exp_slot_a),
		.slot_b    (exp_slot_b),
		.col       (exp_col),
		.hwr_en    (hwr_en),
		.hwr_addr  (hwr_addr),
		.hwr_data  (hwr_data),
		.push      (push),
		.push_pixel(push_pixel),
		.push_last (push_last)
	);

	prx_ofifo #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_pixel(push_pixel),
		.push_last (push_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.frame_last(frame_last),
		.pop       (pop)
	);

endmodule

### hdl/prx_checker.sv
// ----------------------------------------------------------------------------
// prx_checker
// Port-level checks of the pyramid blur unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "pyramid_reduce_expand_blur_unit_macros.svh"

module prx_checker #(
	parameter int PIXEL_BITS = prx_pkg::DEF_PIXEL_BITS
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cfg_valid,
	input logic                               cfg_ready,
	input logic [prx_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [prx_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               mode,
	input logic [PIXEL_BITS-1:0]              pixel_in,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [PIXEL_BITS-1:0]              pixel_out,
	input logic                               frame_last
);

	logic [31:0] pend_q;
	logic        in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// transactions taken minus results delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + 32'(in_acc) - 32'(out_acc);
	end

	`PRX_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(frame_last), "result changed while stalled")
	`PRX_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !out_valid, "result offered during reset")
	`PRX_ASSERT(a_stall_backlog, clk, arst_n, !in_ready |-> out_valid, "input stalled with no result waiting")
	`PRX_ASSERT(a_no_extra, clk, arst_n, out_acc |-> pend_q != 32'd0, "more results than transactions")

endmodule

bind pyramid_reduce_expand_blur_unit prx_checker #(
	.PIXEL_BITS(PIXEL_BITS)
) u_prx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.mode      (mode),
	.pixel_in  (pixel_in),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pixel_out (pixel_out),
	.frame_last(frame_last)
);
